>>> rtl/core/cilp_pkg.sv
package cilp_pkg;

  // Width of the running accumulator; the result port is always 32 bits.
  localparam int VALUE_WIDTH = 32;

  // Character codes used by the parser.
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_SEVEN   = 8'h37;  // '7'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOWER_F = 8'h66;  // 'f'
  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPPER_F = 8'h46;  // 'F'
  localparam logic [7:0] CH_LOWER_X = 8'h78;  // 'x'
  localparam logic [7:0] CH_UPPER_X = 8'h58;  // 'X'

  // Letter digits start at ten.
  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

  // Classification of one byte.
  typedef struct packed {
    logic       is_dec;
    logic       is_oct;
    logic       is_hex;
    logic       is_x;
    logic [3:0] digit;
  } cilp_char_t;

endpackage

>>> rtl/core/cilp_char_class.sv
module cilp_char_class (
  input  logic [7:0]          ch,
  output cilp_pkg::cilp_char_t cls
);
  import cilp_pkg::*;

  logic is_dec;
  logic is_lower;
  logic is_upper;

  // Range checks on the byte.
  assign is_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_lower = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_F);
  assign is_upper = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_F);

  // Flags and the digit value, which is the hex value for any hex digit.
  always_comb begin
    cls.is_dec = is_dec;
    cls.is_oct = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
    cls.is_hex = is_dec || is_lower || is_upper;
    cls.is_x   = (ch == CH_LOWER_X) || (ch == CH_UPPER_X);
    priority if (is_lower) begin
      cls.digit = 4'(ch - CH_LOWER_A) + HEX_LETTER_BASE;
    end else if (is_upper) begin
      cls.digit = 4'(ch - CH_UPPER_A) + HEX_LETTER_BASE;
    end else begin
      cls.digit = 4'(ch - CH_ZERO);
    end
  end

endmodule

>>> rtl/core/cilp_engine.sv
module cilp_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_first,
  input  cilp_pkg::cilp_char_t cls,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   value
);
  import cilp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ZERO,
    PH_OCT,
    PH_HEX,
    PH_DEC
  } phase_t;

  phase_t                   phase, phase_next;
  logic [VALUE_WIDTH-1:0]   accum, accum_next;
  logic                     emit;
  logic [31:0]              result;
  logic [VALUE_WIDTH-1:0]   digit_ext;
  logic [VALUE_WIDTH-1:0]   acc_x8;
  logic [VALUE_WIDTH-1:0]   acc_x10;
  logic [VALUE_WIDTH-1:0]   acc_x16;

  // Constant multiplies are shifts and one add.
  assign digit_ext = VALUE_WIDTH'(cls.digit);
  assign acc_x8    = accum << 3;
  assign acc_x16   = accum << 4;
  assign acc_x10   = (accum << 3) + (accum << 1);

  // Next state and whether this byte ends the number.
  always_comb begin
    phase_next = phase;
    accum_next = accum;
    emit       = 1'b0;
    result     = 32'(signed'(accum));
    if (item_first) begin
      accum_next = '0;
      result     = '0;
      if (!cls.is_dec) begin
        emit       = 1'b1;
        phase_next = PH_IDLE;
      end else if (cls.digit == 4'd0) begin
        phase_next = PH_ZERO;
      end else begin
        phase_next = PH_DEC;
        accum_next = digit_ext;
      end
    end else begin
      unique case (phase)
        PH_ZERO: begin
          if (cls.is_oct) begin
            phase_next = PH_OCT;
            accum_next = acc_x8 + digit_ext;
          end else if (cls.is_x) begin
            phase_next = PH_HEX;
          end else begin
            emit = 1'b1;
          end
        end
        PH_OCT: begin
          if (cls.is_oct) accum_next = acc_x8 + digit_ext;
          else emit = 1'b1;
        end
        PH_HEX: begin
          if (cls.is_hex) accum_next = acc_x16 + digit_ext;
          else emit = 1'b1;
        end
        PH_DEC: begin
          if (cls.is_dec) accum_next = acc_x10 + digit_ext;
          else emit = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
      if (emit) begin
        phase_next = PH_IDLE;
        accum_next = '0;
      end
    end
  end

  // A byte that emits waits for a free output slot; others always go.
  assign take = item_valid && (!emit || !out_valid || out_ready);

  // Parser state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      accum     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        accum <= accum_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
        value     <= result;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // A taken byte that ends a number shows up on the output.
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    take && emit |=> out_valid)
    else $error("emitted value did not reach the output register");

  // The accumulator is clear whenever no number is in progress.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> accum == '0)
    else $error("accumulator not clear while idle");

  // A held result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(take && emit))
    else $error("pending result overwritten");

  // A non-digit first byte yields zero.
  a_nondigit_zero: assert property (@(posedge clk) disable iff (rst)
    take && item_first && !cls.is_dec |=> out_valid && value == '0)
    else $error("non-digit first byte did not give zero");
`endif

endmodule

>>> rtl/core/c_integer_literal_parser.sv
// Channel  Handshake             Payload
// input    in_valid / in_ready   ch[7:0], first
// output   out_valid / out_ready value[31:0] (signed)
//
// One byte is accepted per cycle unless the input stalls; a result is held
// on the output once the byte that ends the number has passed the input
// register and then the parse stage, which registers the result.
// The parse stage updates its state and accumulator as it takes each byte.
// Reset returns the parser to idle with a zero accumulator, no result held.
// While a result waits, bytes that do not end a number still flow; a byte
// that would emit stalls the input until the output slot frees.
module c_integer_literal_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ch,
  input  logic               first,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value
);
  import cilp_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_ch;
  logic       stage_first;
  logic       take;
  cilp_char_t cls;

  // Input register refills when empty or when its byte moves on.
  assign in_ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
      stage_ch    <= ch;
      stage_first <= first;
    end
  end

  // Byte classification.
  cilp_char_class u_class (
    .ch  (stage_ch),
    .cls (cls)
  );

  // Parse state, accumulator and result register.
  cilp_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (stage_valid),
    .item_first (stage_first),
    .cls        (cls),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value)
  );

endmodule
